>>> design/mk2e_pkg.sv
// Shared types and constants for the media key to encoder event converter.
package mk2e_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_REPORT     = 2'd0;
    localparam logic [1:0] CMD_POLL       = 2'd1;
    localparam logic [1:0] CMD_PEER_RESET = 2'd2;

    // Report lengths
    localparam logic [7:0] LEN_USAGE   = 8'd2;
    localparam logic [7:0] LEN_BITMASK = 8'd3;

    // Consumer-control usage codes
    localparam logic [15:0] USAGE_PLAY     = 16'h00CD;
    localparam logic [15:0] USAGE_NEXT     = 16'h00B5;
    localparam logic [15:0] USAGE_PREV     = 16'h00B6;
    localparam logic [15:0] USAGE_VOL_UP   = 16'h00E9;
    localparam logic [15:0] USAGE_VOL_DOWN = 16'h00EA;

    // Bit positions in the bitmask report
    localparam int MASK_VOL_DOWN = 0;
    localparam int MASK_VOL_UP   = 1;
    localparam int MASK_PREV     = 3;
    localparam int MASK_NEXT     = 4;
    localparam int MASK_PLAY     = 5;

    // Internal key vector positions
    localparam int KEY_VOL_UP   = 0;
    localparam int KEY_VOL_DOWN = 1;
    localparam int KEY_NEXT     = 2;
    localparam int KEY_PREV     = 3;
    localparam int KEY_PLAY     = 4;
    localparam int NUM_KEYS     = 5;

    localparam logic signed [15:0] ROT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] ROT_MIN = -16'sh8000;

    // Configuration register indexes and reset values
    localparam logic CFG_DOUBLE_CLICK = 1'b0;
    localparam logic CFG_PUSH_HOLD    = 1'b1;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;
    localparam logic [15:0] PUSH_HOLD_RESET    = 16'd500;

    typedef struct packed {
        logic [15:0] double_click_window_ms;
        logic [15:0] push_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  report_len;
        logic [7:0]  report_lo;
        logic [7:0]  report_hi;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic signed [15:0] rotation;
        logic               was_clicked;
        logic               was_short_pressed;
        logic               is_pressed;
    } t_result;

endpackage

>>> design/mk2e_engine.sv
// Event state and per-item update logic for the media key converter.
module mk2e_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mk2e_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  mk2e_pkg::t_item  i_item,
    output mk2e_pkg::t_result o_result
);

    logic signed [15:0] r_rot, n_rot;
    logic               r_short, n_short;
    logic               r_armed, n_armed;
    logic [31:0]        r_deadline, n_deadline;
    logic [31:0]        r_push_until, n_push_until;
    logic               r_push_valid, n_push_valid;
    logic [mk2e_pkg::NUM_KEYS-1:0] r_prev_keys, n_prev_keys;

    logic [15:0] usage;
    logic        len_ok;
    logic [mk2e_pkg::NUM_KEYS-1:0] keys, rise;
    logic signed [15:0] rot_a, rot_b, rot_c, rot_d;
    logic        push_start;
    logic [31:0] dl_diff, push_left;
    logic        deadline_passed, push_active, click_fire;

    assign usage  = {i_item.report_hi, i_item.report_lo};
    assign len_ok = (i_item.report_len == mk2e_pkg::LEN_USAGE) ||
                    (i_item.report_len == mk2e_pkg::LEN_BITMASK);

    always_comb begin
        keys = '0;
        if (i_item.report_len == mk2e_pkg::LEN_USAGE) begin
            keys[mk2e_pkg::KEY_VOL_UP]   = (usage == mk2e_pkg::USAGE_VOL_UP);
            keys[mk2e_pkg::KEY_VOL_DOWN] = (usage == mk2e_pkg::USAGE_VOL_DOWN);
            keys[mk2e_pkg::KEY_NEXT]     = (usage == mk2e_pkg::USAGE_NEXT);
            keys[mk2e_pkg::KEY_PREV]     = (usage == mk2e_pkg::USAGE_PREV);
            keys[mk2e_pkg::KEY_PLAY]     = (usage == mk2e_pkg::USAGE_PLAY);
        end else begin
            keys[mk2e_pkg::KEY_VOL_UP]   = i_item.report_lo[mk2e_pkg::MASK_VOL_UP];
            keys[mk2e_pkg::KEY_VOL_DOWN] = i_item.report_lo[mk2e_pkg::MASK_VOL_DOWN];
            keys[mk2e_pkg::KEY_NEXT]     = i_item.report_lo[mk2e_pkg::MASK_NEXT];
            keys[mk2e_pkg::KEY_PREV]     = i_item.report_lo[mk2e_pkg::MASK_PREV];
            keys[mk2e_pkg::KEY_PLAY]     = i_item.report_lo[mk2e_pkg::MASK_PLAY];
        end
    end

    assign rise = keys & ~r_prev_keys;

    // Four saturating steps in key order; a dropped track step starts no push
    always_comb begin
        push_start = 1'b0;
        rot_a = r_rot;
        if (rise[mk2e_pkg::KEY_VOL_UP] && (r_rot != mk2e_pkg::ROT_MAX)) begin
            rot_a = r_rot + 16'sd1;
        end
        rot_b = rot_a;
        if (rise[mk2e_pkg::KEY_VOL_DOWN] && (rot_a != mk2e_pkg::ROT_MIN)) begin
            rot_b = rot_a - 16'sd1;
        end
        rot_c = rot_b;
        if (rise[mk2e_pkg::KEY_NEXT] && (rot_b != mk2e_pkg::ROT_MAX)) begin
            rot_c = rot_b + 16'sd1;
            push_start = 1'b1;
        end
        rot_d = rot_c;
        if (rise[mk2e_pkg::KEY_PREV] && (rot_c != mk2e_pkg::ROT_MIN)) begin
            rot_d = rot_c - 16'sd1;
            push_start = 1'b1;
        end
    end

    assign dl_diff         = i_item.now_ms - r_deadline;
    assign deadline_passed = ~dl_diff[31];
    assign push_left       = r_push_until - i_item.now_ms;
    assign push_active     = r_push_valid && (push_left != 32'd0) && !push_left[31];
    // A click cannot be left pending across a poll, so it is decided here only
    assign click_fire = (r_rot == 16'sd0) && !r_short && r_armed && deadline_passed;

    assign o_result.rotation          = r_rot;
    assign o_result.was_clicked       = click_fire;
    assign o_result.was_short_pressed = r_short;
    assign o_result.is_pressed        = r_prev_keys[mk2e_pkg::KEY_NEXT] ||
                                        r_prev_keys[mk2e_pkg::KEY_PREV] || push_active;

    always_comb begin
        n_rot        = r_rot;
        n_short      = r_short;
        n_armed      = r_armed;
        n_deadline   = r_deadline;
        n_push_until = r_push_until;
        n_push_valid = r_push_valid;
        n_prev_keys  = r_prev_keys;
        if (i_valid) begin
            unique case (i_item.cmd)
                mk2e_pkg::CMD_REPORT: begin
                    if (len_ok) begin
                        n_rot       = rot_d;
                        n_prev_keys = keys;
                        if (push_start) begin
                            n_push_until = i_item.now_ms + {16'd0, i_cfg.push_hold_ms};
                            n_push_valid = 1'b1;
                        end
                        if (!keys[mk2e_pkg::KEY_PLAY] && r_prev_keys[mk2e_pkg::KEY_PLAY]) begin
                            if (r_armed && !deadline_passed) begin
                                n_short    = 1'b1;
                                n_armed    = 1'b0;
                                n_deadline = '0;
                            end else begin
                                n_armed    = 1'b1;
                                n_deadline = i_item.now_ms +
                                             {16'd0, i_cfg.double_click_window_ms};
                            end
                        end
                    end
                end
                mk2e_pkg::CMD_POLL: begin
                    n_rot   = '0;
                    n_short = 1'b0;
                    if (click_fire) begin
                        n_armed    = 1'b0;
                        n_deadline = '0;
                    end
                end
                mk2e_pkg::CMD_PEER_RESET: begin
                    n_rot        = '0;
                    n_short      = 1'b0;
                    n_armed      = 1'b0;
                    n_deadline   = '0;
                    n_push_until = '0;
                    n_push_valid = 1'b0;
                    n_prev_keys  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot        <= '0;
            r_short      <= 1'b0;
            r_armed      <= 1'b0;
            r_deadline   <= '0;
            r_push_until <= '0;
            r_push_valid <= 1'b0;
            r_prev_keys  <= '0;
        end else begin
            r_rot        <= n_rot;
            r_short      <= n_short;
            r_armed      <= n_armed;
            r_deadline   <= n_deadline;
            r_push_until <= n_push_until;
            r_push_valid <= n_push_valid;
            r_prev_keys  <= n_prev_keys;
        end
    end

endmodule

>>> design/media_key_to_encoder_events_core.sv
// Top level of the media key to encoder event converter.
//
// Input stream (s_axis): one transfer per command. tuser selects the command:
// input report, poll for events, or peer reset. tdata carries the report
// length and bytes plus the current millisecond time. Reports update the
// pending rotation, click and short-press state; a peer reset clears it all.
// Only a poll produces an output transfer (m_axis) with the pending rotation,
// click, short-press and pressed flags; the poll then clears the pending events.
// Timing: an accepted item is held in the input register until it advances;
// then the state and, for a poll, the output register update, so a poll
// result shows on m_axis straight from the output register and can transfer
// as soon as the receiver is ready.
// Throughput: one item per cycle while no poll waits on a stalled result, set
// by the single-pass state update between the input and result registers.
// When the receiver stalls, the result stays in the output register; reports
// and resets keep flowing, and only a further poll waits for the register.
// Reset (i_rst_n, synchronous, active low) empties both registers, clears all
// event state and loads the config defaults (300 ms window, 500 ms push hold).
// Config writes (i_cfg_we) are taken at any edge and are meant for idle time.
module media_key_to_encoder_events_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // report_len[7:0], report_lo[15:8],
                                       // report_hi[23:16], now_ms[55:24]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // rotation[15:0], was_clicked[16],
                                       // was_short_pressed[17], is_pressed[18],
                                       // zero[23:19]
);

    mk2e_pkg::t_cfg    r_cfg;
    mk2e_pkg::t_item   r_item;
    mk2e_pkg::t_result r_out, engine_result;
    logic r_item_valid;
    logic r_out_valid;
    logic in_fire, advance, item_is_poll;

    // Hold the config registers; there is no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_click_window_ms <= mk2e_pkg::DOUBLE_CLICK_RESET;
            r_cfg.push_hold_ms           <= mk2e_pkg::PUSH_HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mk2e_pkg::CFG_DOUBLE_CLICK: r_cfg.double_click_window_ms <= i_cfg_data;
                mk2e_pkg::CFG_PUSH_HOLD:    r_cfg.push_hold_ms           <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A poll waits only while the output register holds an untaken result
    assign item_is_poll  = (r_item.cmd == mk2e_pkg::CMD_POLL);
    assign advance       = r_item_valid &&
                           (!item_is_poll || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_item_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_fire) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    // Input payload register: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.cmd        <= s_axis_tuser;
            r_item.report_len <= s_axis_tdata[7:0];
            r_item.report_lo  <= s_axis_tdata[15:8];
            r_item.report_hi  <= s_axis_tdata[23:16];
            r_item.now_ms     <= s_axis_tdata[55:24];
        end
    end

    mk2e_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (advance),
        .i_item   (r_item),
        .o_result (engine_result)
    );

    // Output register: load on an advancing poll, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && item_is_poll) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && item_is_poll) begin
            r_out <= engine_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.is_pressed, r_out.was_short_pressed,
                            r_out.was_clicked, r_out.rotation};

    // An empty input register always takes a transfer
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_item_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    // Every advancing poll yields a result on the next cycle
    a_poll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && item_is_poll) |=> m_axis_tvalid)
        else $error("poll advanced without a result");

    // A poll blocked by a stalled result holds the input side
    a_poll_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && item_is_poll && m_axis_tvalid && !m_axis_tready)
        |-> (!s_axis_tready && !advance))
        else $error("poll overran a stalled result");

    // Non-poll items never create a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !(advance && item_is_poll)) |=> !m_axis_tvalid)
        else $error("result appeared without a poll");

endmodule

>>> sim/media_key_to_encoder_events_core_tb.sv
// Self-checking testbench for the media key to encoder event converter core.
`timescale 1ns / 100ps

module media_key_to_encoder_events_core_tb;

    // cmd 3 has no meaning in the block; give it a name for the stimulus
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [15:0] NO_USAGE   = 16'h0000;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE_CYCLES = 4;   // input register + result register + margin
    localparam int          PHASE_ITEMS = 125;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // report_len[7:0], report_lo[15:8], report_hi[23:16],
                                 // now_ms[55:24]
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // rotation[15:0], was_clicked[16], was_short_pressed[17],
                                 // is_pressed[18], zero[23:19]

    media_key_to_encoder_events_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Event predictor: mirror of the converter state and its registers
    // ------------------------------------------------------------------
    logic [15:0]        window_ms;
    logic [15:0]        hold_ms;
    logic signed [15:0] acc_rotation;
    bit                 click_pend;
    bit                 short_pend;
    bit                 click_armed_q;
    logic [31:0]        click_due;
    logic [31:0]        push_due;
    bit                 push_live;
    logic [4:0]         held_keys;

    mk2e_pkg::t_result  event_q[$];    // poll results still to arrive
    mk2e_pkg::t_item    pend_q[$];     // commands waiting to be sent

    int n_items, n_polls, n_clicks, n_shorts, n_pressed, fail_count, cycle_count;
    int send_gap_pct, recv_stall_pct;

    // a is at or after b in wrapping millisecond time
    function automatic bit not_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic logic [4:0] keys_of(mk2e_pkg::t_item it);
        logic [15:0] v;
        logic [4:0]  k;
        v = {it.report_hi, it.report_lo};
        k = '0;
        if (it.report_len == mk2e_pkg::LEN_USAGE) begin
            case (v)
                mk2e_pkg::USAGE_VOL_UP:   k[mk2e_pkg::KEY_VOL_UP]   = 1'b1;
                mk2e_pkg::USAGE_VOL_DOWN: k[mk2e_pkg::KEY_VOL_DOWN] = 1'b1;
                mk2e_pkg::USAGE_NEXT:     k[mk2e_pkg::KEY_NEXT]     = 1'b1;
                mk2e_pkg::USAGE_PREV:     k[mk2e_pkg::KEY_PREV]     = 1'b1;
                mk2e_pkg::USAGE_PLAY:     k[mk2e_pkg::KEY_PLAY]     = 1'b1;
                default:                  ;
            endcase
        end else begin
            k[mk2e_pkg::KEY_VOL_UP]   = v[mk2e_pkg::MASK_VOL_UP];
            k[mk2e_pkg::KEY_VOL_DOWN] = v[mk2e_pkg::MASK_VOL_DOWN];
            k[mk2e_pkg::KEY_NEXT]     = v[mk2e_pkg::MASK_NEXT];
            k[mk2e_pkg::KEY_PREV]     = v[mk2e_pkg::MASK_PREV];
            k[mk2e_pkg::KEY_PLAY]     = v[mk2e_pkg::MASK_PLAY];
        end
        return k;
    endfunction

    task automatic clear_events();
        acc_rotation  = '0;
        click_pend    = 1'b0;
        short_pend    = 1'b0;
        click_armed_q = 1'b0;
        click_due     = '0;
        push_due      = '0;
        push_live     = 1'b0;
        held_keys     = '0;
    endtask

    // Advance the mirrored state by one accepted command
    task automatic update_events(input mk2e_pkg::t_item it);
        logic [4:0] keys;
        logic [4:0] rise;
        mk2e_pkg::t_result r;
        case (it.cmd)
            mk2e_pkg::CMD_REPORT: begin
                if (it.report_len == mk2e_pkg::LEN_USAGE ||
                    it.report_len == mk2e_pkg::LEN_BITMASK) begin
                    keys = keys_of(it);
                    rise = keys & ~held_keys;
                    // steps past either limit are dropped, a dropped track key starts no push
                    if (rise[mk2e_pkg::KEY_VOL_UP] && acc_rotation != mk2e_pkg::ROT_MAX)
                        acc_rotation = acc_rotation + 16'sd1;
                    if (rise[mk2e_pkg::KEY_VOL_DOWN] && acc_rotation != mk2e_pkg::ROT_MIN)
                        acc_rotation = acc_rotation - 16'sd1;
                    if (rise[mk2e_pkg::KEY_NEXT] && acc_rotation != mk2e_pkg::ROT_MAX) begin
                        acc_rotation = acc_rotation + 16'sd1;
                        push_due  = it.now_ms + {16'h0, hold_ms};
                        push_live = 1'b1;
                    end
                    if (rise[mk2e_pkg::KEY_PREV] && acc_rotation != mk2e_pkg::ROT_MIN) begin
                        acc_rotation = acc_rotation - 16'sd1;
                        push_due  = it.now_ms + {16'h0, hold_ms};
                        push_live = 1'b1;
                    end
                    // play release: second one inside the window is a short press
                    if (!keys[mk2e_pkg::KEY_PLAY] && held_keys[mk2e_pkg::KEY_PLAY]) begin
                        if (click_armed_q && !not_before(it.now_ms, click_due)) begin
                            short_pend    = 1'b1;
                            click_armed_q = 1'b0;
                            click_due     = '0;
                        end else begin
                            click_armed_q = 1'b1;
                            click_due     = it.now_ms + {16'h0, window_ms};
                        end
                    end
                    held_keys = keys;
                end
            end
            mk2e_pkg::CMD_POLL: begin
                // a click only surfaces when nothing else is waiting
                if (acc_rotation == 0 && !click_pend && !short_pend && click_armed_q &&
                    not_before(it.now_ms, click_due)) begin
                    click_pend    = 1'b1;
                    click_armed_q = 1'b0;
                    click_due     = '0;
                end
                r.rotation          = acc_rotation;
                r.was_clicked       = click_pend;
                r.was_short_pressed = short_pend;
                r.is_pressed        = held_keys[mk2e_pkg::KEY_NEXT] ||
                                      held_keys[mk2e_pkg::KEY_PREV] ||
                                      (push_live && push_due != it.now_ms &&
                                       not_before(push_due, it.now_ms));
                event_q.push_back(r);
                n_polls   += 1;
                n_clicks  += r.was_clicked;
                n_shorts  += r.was_short_pressed;
                n_pressed += r.is_pressed;
                acc_rotation = '0;
                click_pend   = 1'b0;
                short_pend   = 1'b0;
            end
            mk2e_pkg::CMD_PEER_RESET: clear_events();
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input transfer tracking, result checking and run limit
    // ------------------------------------------------------------------
    mk2e_pkg::t_item drv_item;
    bit    in_fire;

    always @(posedge i_clk) begin : watch
        mk2e_pkg::t_result exp_r;
        mk2e_pkg::t_result got_r;
        cycle_count += 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end else begin
            in_fire = 1'b0;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                in_fire = 1'b1;
                n_items += 1;
                update_events(drv_item);
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_r.rotation          = m_axis_tdata[15:0];
                got_r.was_clicked       = m_axis_tdata[16];
                got_r.was_short_pressed = m_axis_tdata[17];
                got_r.is_pressed        = m_axis_tdata[18];
                if (event_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    fail_count += 1;
                end else begin
                    exp_r = event_q.pop_front();
                    if (got_r.rotation !== exp_r.rotation) begin
                        $error("rotation: expected %0d, got %0d", exp_r.rotation,
                               got_r.rotation);
                        fail_count += 1;
                    end
                    if (got_r.was_clicked !== exp_r.was_clicked) begin
                        $error("was_clicked: expected %0b, got %0b", exp_r.was_clicked,
                               got_r.was_clicked);
                        fail_count += 1;
                    end
                    if (got_r.was_short_pressed !== exp_r.was_short_pressed) begin
                        $error("was_short_pressed: expected %0b, got %0b",
                               exp_r.was_short_pressed, got_r.was_short_pressed);
                        fail_count += 1;
                    end
                    if (got_r.is_pressed !== exp_r.is_pressed) begin
                        $error("is_pressed: expected %0b, got %0b", exp_r.is_pressed,
                               got_r.is_pressed);
                        fail_count += 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: feed commands and pace the result side on the falling edge
    // ------------------------------------------------------------------
    int burst_left;

    always @(negedge i_clk) begin : drive
        bit quiet;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            // occasional bursts where neither side idles
            quiet = (burst_left > 0);
            if (burst_left > 0)
                burst_left -= 1;
            else if ($urandom_range(0, 99) < 3)
                burst_left = $urandom_range(10, 40);
            // hold the current transfer until it is taken
            if (!s_axis_tvalid || in_fire) begin
                if (pend_q.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= send_gap_pct)) begin
                    drv_item = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {drv_item.now_ms, drv_item.report_hi,
                                      drv_item.report_lo, drv_item.report_len};
                    s_axis_tuser  <= drv_item.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] now_t;

    task automatic put(input logic [1:0] cmd, input logic [7:0] len,
                       input logic [15:0] code, input logic [31:0] t);
        mk2e_pkg::t_item it;
        it.cmd        = cmd;
        it.report_len = len;
        it.report_lo  = code[7:0];
        it.report_hi  = code[15:8];
        it.now_ms     = t;
        pend_q.push_back(it);
    endtask

    // Block until every command is sent and every poll result is back
    task automatic wait_idle();
        while (pend_q.size() != 0 || s_axis_tvalid || event_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == mk2e_pkg::CFG_DOUBLE_CLICK)
            window_ms = value;
        else
            hold_ms = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_usage();
        case ($urandom_range(0, 4))
            0:       return mk2e_pkg::USAGE_VOL_UP;
            1:       return mk2e_pkg::USAGE_VOL_DOWN;
            2:       return mk2e_pkg::USAGE_NEXT;
            3:       return mk2e_pkg::USAGE_PREV;
            default: return mk2e_pkg::USAGE_PLAY;
        endcase
    endfunction

    // Mostly well-formed key taps and polls, with noise and broken reports mixed in
    task automatic add_traffic(input int target);
        int          cnt;
        int          kind;
        int          r;
        logic [15:0] code;
        logic [15:0] rel_code;
        logic [7:0]  mask_lo;
        cnt = 0;
        while (cnt < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                now_t += $urandom_range(0, 120);
            else if (r < 90)
                now_t += $urandom_range(100, 800);
            else if (r < 97)
                now_t += $urandom_range(0, 70000);
            else
                now_t = $urandom;
            rel_code = ($urandom_range(0, 1) == 0) ? NO_USAGE : 16'($urandom);
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                // press, maybe poll while held, release
                code = pick_usage();
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, code, now_t);
                if ($urandom_range(0, 1) == 1)
                    put(mk2e_pkg::CMD_POLL, 8'($urandom), 16'($urandom), now_t);
                now_t += $urandom_range(0, 200);
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, rel_code, now_t);
                cnt += 3;
            end else if (kind < 42) begin
                // play tapped twice, gap spread around the window
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_PLAY, now_t);
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, rel_code, now_t);
                now_t += $urandom_range(0, 2 * int'(window_ms) + 1);
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK,
                    16'(1 << mk2e_pkg::MASK_PLAY), now_t);
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK, NO_USAGE, now_t);
                cnt += 4;
            end else if (kind < 57) begin
                mask_lo = 8'($urandom) & (($urandom_range(0, 3) == 0) ? 8'hFF : 8'h3B);
                put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK, {8'($urandom), mask_lo},
                    now_t);
                cnt += 1;
            end else if (kind < 82) begin
                put(mk2e_pkg::CMD_POLL, 8'($urandom), 16'($urandom), now_t);
                cnt += 1;
            end else if (kind < 86) begin
                put(mk2e_pkg::CMD_PEER_RESET, 8'($urandom), 16'($urandom), now_t);
                cnt += 1;
            end else if (kind < 89) begin
                put(CMD_UNUSED, 8'($urandom), 16'($urandom), $urandom);
            end else if (kind < 95) begin
                // report of any length; only the meaningful ones count
                put(mk2e_pkg::CMD_REPORT, 8'($urandom), 16'($urandom), now_t);
                if (pend_q[$].report_len == mk2e_pkg::LEN_USAGE ||
                    pend_q[$].report_len == mk2e_pkg::LEN_BITMASK)
                    cnt += 1;
            end else begin
                put(2'($urandom), 8'($urandom), 16'($urandom), $urandom);
                cnt += 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = mk2e_pkg::CFG_DOUBLE_CLICK;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = mk2e_pkg::CMD_REPORT;
        m_axis_tready  = 1'b0;
        in_fire        = 1'b0;
        burst_left     = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        n_items = 0; n_polls = 0; n_clicks = 0; n_shorts = 0; n_pressed = 0;
        fail_count = 0; cycle_count = 0;
        window_ms = mk2e_pkg::DOUBLE_CLICK_RESET;
        hold_ms   = mk2e_pkg::PUSH_HOLD_RESET;
        clear_events();
        now_t = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on reset register values
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_VOL_UP, 32'd0);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_VOL_UP,
            32'd1);                                                // still held, no step
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_VOL_DOWN, 32'd2);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_VOL_DOWN, 32'd3);
        put(mk2e_pkg::CMD_POLL, 8'hFF, 16'hFFFF, 32'd4);          // push never started
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_NEXT,
            32'hFFFF_FF00);                                        // push deadline wraps
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'hFFFF_FFFF);  // key held
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK, NO_USAGE, 32'hFFFF_FFFF);
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h0000_0010);  // push still active
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h0000_00F4);  // push ends exactly now
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK, 16'hFFFF,
            32'h8000_0000);                                        // every key at once
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_BITMASK, 16'hFF00,
            32'h8000_0000);                                        // release, arm click
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h8000_0000);  // before the deadline
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h8000_012C);  // click surfaces
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_PLAY, 32'h8000_1000);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, 16'h1234, 32'h8000_1000);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_PLAY, 32'h8000_1005);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, NO_USAGE,
            32'h8000_100A);                                        // second release: short
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h8000_100A);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, mk2e_pkg::USAGE_PREV, 32'h8000_2000);
        put(mk2e_pkg::CMD_PEER_RESET, 8'hFF, 16'hFFFF,
            32'hFFFF_FFFF);                                        // wipes held key and push
        put(CMD_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        put(mk2e_pkg::CMD_REPORT, 8'h00, mk2e_pkg::USAGE_VOL_UP,
            32'h8000_2001);                                        // wrong lengths ignored
        put(mk2e_pkg::CMD_REPORT, 8'hFF, mk2e_pkg::USAGE_VOL_UP, 32'h8000_2002);
        put(mk2e_pkg::CMD_REPORT, mk2e_pkg::LEN_USAGE, 16'hFFE9,
            32'h8000_2003);                                        // high byte spoils code
        put(mk2e_pkg::CMD_POLL, 8'h00, NO_USAGE, 32'h8000_2004);
        wait_idle();

        // Random traffic, one pacing and register setting per phase
        write_reg(mk2e_pkg::CFG_DOUBLE_CLICK, mk2e_pkg::DOUBLE_CLICK_RESET);
        write_reg(mk2e_pkg::CFG_PUSH_HOLD, mk2e_pkg::PUSH_HOLD_RESET);
        add_traffic(PHASE_ITEMS);
        wait_idle();

        write_reg(mk2e_pkg::CFG_DOUBLE_CLICK, 16'd0);
        write_reg(mk2e_pkg::CFG_PUSH_HOLD, 16'd0);
        send_gap_pct = 48;
        add_traffic(PHASE_ITEMS);
        wait_idle();

        write_reg(mk2e_pkg::CFG_DOUBLE_CLICK, 16'hFFFF);
        write_reg(mk2e_pkg::CFG_PUSH_HOLD, 16'hFFFF);
        send_gap_pct   = 0;
        recv_stall_pct = 48;
        add_traffic(PHASE_ITEMS);
        wait_idle();

        write_reg(mk2e_pkg::CFG_DOUBLE_CLICK, 16'($urandom_range(20, 400)));
        write_reg(mk2e_pkg::CFG_PUSH_HOLD, 16'($urandom_range(1, 1000)));
        send_gap_pct   = 31;
        recv_stall_pct = 31;
        add_traffic(PHASE_ITEMS / 2);
        wait_idle();                       // sender holds off until all results are back
        add_traffic(PHASE_ITEMS / 2);
        wait_idle();

        $display("covered %0d command transfers and %0d poll results", n_items, n_polls);
        $display("  with %0d clicks, %0d short presses, %0d pressed, four pacing phases",
                 n_clicks, n_shorts, n_pressed);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
